[rtl/ecurve_pkg.sv]
package ecurve_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int VALUE_BITS = 32;
   localparam int LANES      = 2;

   localparam logic [3:0] OP_LINEAR      = 4'd0;
   localparam logic [3:0] OP_QUAD_IN     = 4'd1;
   localparam logic [3:0] OP_QUAD_OUT    = 4'd2;
   localparam logic [3:0] OP_QUAD_INOUT  = 4'd3;
   localparam logic [3:0] OP_CUBIC_IN    = 4'd4;
   localparam logic [3:0] OP_CUBIC_OUT   = 4'd5;
   localparam logic [3:0] OP_CUBIC_INOUT = 4'd6;
   localparam logic [3:0] OP_CIRC_IN     = 4'd7;
   localparam logic [3:0] OP_CIRC_OUT    = 4'd8;
   localparam logic [3:0] OP_CIRC_INOUT  = 4'd9;
   localparam logic [3:0] OP_EXP_IN      = 4'd10;
   localparam logic [3:0] OP_EXP_OUT     = 4'd11;
   localparam logic [3:0] OP_EXP_INOUT   = 4'd12;

   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_LIN,
      CLS_QUAD,
      CLS_CUBIC,
      CLS_CIRC,
      CLS_EXP
   } cls_type;

   // rounded square root, digit by digit; elaboration use only
   function automatic logic [63:0] root_rnd(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = x_in;
      r = '0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (x > r) r = r + 64'd1;
      return r;
   endfunction

   // 2^(-2^-k) in Q1.30
   function automatic logic [30:0] pow_tab(input int k);
      logic [63:0] t;
      t = 64'd1 << 29;
      for (int i = 1; i <= k; i++) t = root_rnd(t << 30);
      return t[30:0];
   endfunction

endpackage

[rtl/ecurve_req_if.sv]
interface ecurve_req_if #(
   parameter int FRAC_BITS  = ecurve_pkg::FRAC_BITS,
   parameter int VALUE_BITS = ecurve_pkg::VALUE_BITS
);
   logic                         valid;
   logic                         ready;
   logic [3:0]                   opcode;
   logic signed [VALUE_BITS-1:0] start_x;
   logic signed [VALUE_BITS-1:0] start_y;
   logic signed [VALUE_BITS-1:0] end_x;
   logic signed [VALUE_BITS-1:0] end_y;
   logic [FRAC_BITS:0]           progress;

   modport source (output valid, opcode, start_x, start_y, end_x, end_y, progress,
                   input ready);
   modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, progress,
                   output ready);
endinterface

[rtl/ecurve_rsp_if.sv]
interface ecurve_rsp_if #(
   parameter int VALUE_BITS = ecurve_pkg::VALUE_BITS
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value_x;
   logic signed [VALUE_BITS-1:0] value_y;
   logic                         saturated;

   modport source (output valid, value_x, value_y, saturated, input ready);
   modport sink   (input valid, value_x, value_y, saturated, output ready);
endinterface

[rtl/ecurve_weight.sv]
module ecurve_weight #(
   parameter int FRAC_BITS = ecurve_pkg::FRAC_BITS
) (
   input  logic               clock,
   input  logic               en,
   input  logic [3:0]         opcode,
   input  logic [FRAC_BITS:0] progress,
   output logic [FRAC_BITS:0] weight
);
   localparam int F    = FRAC_BITS;
   localparam int LAST = F + 4;
   localparam logic [F:0] ONE  = (F+1)'(1) << F;
   localparam logic [F:0] HALF = (F+1)'(1) << (F - 1);

   typedef struct packed {
      ecurve_pkg::cls_type cls;
      logic                cpl;
      logic                inout_m;
      logic [F:0]          p;
      logic [F:0]          b;
      logic [1:0]          m1;
      logic                m2;
      logic [F+3:0]        e;
      logic [F:0]          sq;
      logic [F:0]          poly;
      logic [30:0]         pr;
      logic [F:0]          pw;
      logic [2*F:0]        rx;
      logic [2*F+1:0]      rr;
      logic [F:0]          w;
   } stage_type;

   stage_type st_ff [0:LAST];
   stage_type st_in [0:LAST];

   always_comb begin
      logic [F:0]          p;
      logic [F:0]          q;
      logic [F:0]          eb;
      logic                lo;
      logic                is_out;
      logic                is_inout;
      ecurve_pkg::cls_type cls;
      p        = (progress > ONE) ? ONE : progress;
      q        = ONE - p;
      lo       = p < HALF;
      is_out   = 1'b0;
      is_inout = 1'b0;
      case (opcode)
         ecurve_pkg::OP_LINEAR:      cls = ecurve_pkg::CLS_LIN;
         ecurve_pkg::OP_QUAD_IN:     cls = ecurve_pkg::CLS_QUAD;
         ecurve_pkg::OP_QUAD_OUT: begin
            cls = ecurve_pkg::CLS_QUAD; is_out = 1'b1;
         end
         ecurve_pkg::OP_QUAD_INOUT: begin
            cls = ecurve_pkg::CLS_QUAD; is_inout = 1'b1;
         end
         ecurve_pkg::OP_CUBIC_IN:    cls = ecurve_pkg::CLS_CUBIC;
         ecurve_pkg::OP_CUBIC_OUT: begin
            cls = ecurve_pkg::CLS_CUBIC; is_out = 1'b1;
         end
         ecurve_pkg::OP_CUBIC_INOUT: begin
            cls = ecurve_pkg::CLS_CUBIC; is_inout = 1'b1;
         end
         ecurve_pkg::OP_CIRC_IN:     cls = ecurve_pkg::CLS_CIRC;
         ecurve_pkg::OP_CIRC_OUT: begin
            cls = ecurve_pkg::CLS_CIRC; is_out = 1'b1;
         end
         ecurve_pkg::OP_CIRC_INOUT: begin
            cls = ecurve_pkg::CLS_CIRC; is_inout = 1'b1;
         end
         ecurve_pkg::OP_EXP_IN:      cls = ecurve_pkg::CLS_EXP;
         ecurve_pkg::OP_EXP_OUT: begin
            cls = ecurve_pkg::CLS_EXP; is_out = 1'b1;
         end
         ecurve_pkg::OP_EXP_INOUT: begin
            cls = ecurve_pkg::CLS_EXP; is_inout = 1'b1;
         end
         default:                    cls = ecurve_pkg::CLS_NONE;
      endcase
      st_in[0]         = '0;
      st_in[0].cls     = cls;
      st_in[0].p       = p;
      st_in[0].inout_m = is_inout;
      st_in[0].cpl     = is_out | (is_inout & ~lo);
      st_in[0].b       = is_inout ? (lo ? p : q) : (is_out ? q : p);
      // exponential in runs on q, out on p
      eb = is_inout ? st_in[0].b : (is_out ? p : q);
      if (is_inout)
         st_in[0].e = ((F+4)'(11) << F) - (((F+4)'(eb) << 4) + ((F+4)'(eb) << 2));
      else
         st_in[0].e = ((F+4)'(eb) << 3) + ((F+4)'(eb) << 1);
      if (is_inout && cls == ecurve_pkg::CLS_CIRC)       st_in[0].m1 = 2'd2;
      else if (is_inout && cls == ecurve_pkg::CLS_QUAD)  st_in[0].m1 = 2'd1;
      else                                               st_in[0].m1 = 2'd0;
      st_in[0].m2 = is_inout && cls == ecurve_pkg::CLS_CUBIC;
      st_in[0].pr = 31'd1 << 30;
   end

   always_ff @(posedge clock) begin
      if (en) st_ff[0] <= st_in[0];
   end

   for (genvar j = 1; j <= LAST; j++) begin : g_stage
      localparam int K  = (j <= F) ? j : 1;
      localparam logic [30:0] TK = ecurve_pkg::pow_tab(K);
      localparam int RI = (j >= 3 && j <= F + 3) ? j - 3 : 0;
      localparam logic [2*F+1:0] RBIT = (2*F+2)'(1) << (2 * (F - RI));

      always_comb begin
         logic [2*F+3:0] sqp;
         logic [2*F+3:0] sqs;
         logic [2*F+3:0] cbp;
         logic [2*F+3:0] cbs;
         logic [61:0]    pm;
         logic [5:0]     sh;
         logic [40:0]    pa;
         logic [2*F+1:0] rt;
         logic [F+1:0]   root;
         logic [F+1:0]   cw;
         st_in[j] = st_ff[j-1];

         sqp = (2*F+4)'(st_ff[j-1].b) * (2*F+4)'(st_ff[j-1].b);
         sqs = ((sqp << st_ff[j-1].m1) + (2*F+4)'(HALF)) >> F;
         if (j == 1) st_in[j].sq = (sqs > (2*F+4)'(ONE)) ? ONE : sqs[F:0];

         cbp = (2*F+4)'(st_ff[j-1].sq) * (2*F+4)'(st_ff[j-1].b);
         cbs = ((cbp << (st_ff[j-1].m2 ? 2 : 0)) + (2*F+4)'(HALF)) >> F;
         if (j == 2) begin
            st_in[j].poly = (st_ff[j-1].cls == ecurve_pkg::CLS_CUBIC) ? cbs[F:0]
                                                                    : st_ff[j-1].sq;
            st_in[j].rx   = (2*F+1)'(ONE - st_ff[j-1].sq) << F;
            st_in[j].rr   = '0;
         end

         // one fraction bit of the exponent per stage
         pm = 62'(st_ff[j-1].pr) * 62'(TK) + (62'd1 << 29);
         if (j <= F && st_ff[j-1].e[F-K]) st_in[j].pr = pm[60:30];

         sh = 6'(30 - F) + 6'(st_ff[j-1].e[F+3:F]);
         pa = (41'(st_ff[j-1].pr) + (41'd1 << (sh - 6'd1))) >> sh;
         if (j == F + 1) st_in[j].pw = (sh > 6'd40) ? '0 : pa[F:0];

         // one root digit per stage
         rt = st_ff[j-1].rr + RBIT;
         if (j >= 3 && j <= F + 3) begin
            if ({1'b0, st_ff[j-1].rx} >= rt) begin
               st_in[j].rx = st_ff[j-1].rx - rt[2*F:0];
               st_in[j].rr = (st_ff[j-1].rr >> 1) + RBIT;
            end else begin
               st_in[j].rr = st_ff[j-1].rr >> 1;
            end
         end

         root = st_ff[j-1].rr[F+1:0]
              + (({1'b0, st_ff[j-1].rx} > st_ff[j-1].rr) ? (F+2)'(1) : (F+2)'(0));
         if (st_ff[j-1].cpl) cw = (F+2)'(ONE) + root + (F+2)'(1);
         else                cw = (F+2)'(ONE) - root + (F+2)'(1);
         if (j == LAST) begin
            case (st_ff[j-1].cls)
               ecurve_pkg::CLS_LIN:   st_in[j].w = st_ff[j-1].p;
               ecurve_pkg::CLS_QUAD,
               ecurve_pkg::CLS_CUBIC: st_in[j].w = st_ff[j-1].cpl ? ONE - st_ff[j-1].poly
                                                                  : st_ff[j-1].poly;
               ecurve_pkg::CLS_CIRC: begin
                  if (st_ff[j-1].inout_m) st_in[j].w = cw[F+1:1];
                  else if (st_ff[j-1].cpl) st_in[j].w = root[F:0];
                  else st_in[j].w = ONE - root[F:0];
               end
               ecurve_pkg::CLS_EXP:   st_in[j].w = st_ff[j-1].cpl ? ONE - st_ff[j-1].pw
                                                                  : st_ff[j-1].pw;
               default:               st_in[j].w = '0;
            endcase
         end
      end

      always_ff @(posedge clock) begin
         if (en) st_ff[j] <= st_in[j];
      end
   end

   assign weight = st_ff[LAST].w;

endmodule

[rtl/ecurve_lane.sv]
module ecurve_lane #(
   parameter int FRAC_BITS  = ecurve_pkg::FRAC_BITS,
   parameter int VALUE_BITS = ecurve_pkg::VALUE_BITS
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [VALUE_BITS-1:0] start_v,
   input  logic signed [VALUE_BITS-1:0] end_v,
   input  logic [FRAC_BITS:0]           weight,
   output logic signed [VALUE_BITS-1:0] result,
   output logic                         sat
);
   localparam int F   = FRAC_BITS;
   localparam int VB  = VALUE_BITS;
   localparam int DLY = F + 5;
   localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
   localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

   typedef struct packed {
      logic [VB-1:0] s;
      logic [VB:0]   mag;
      logic          neg;
   } line_type;

   line_type      line_ff [0:DLY-1];
   line_type      line_in;
   line_type      scl_ff;
   line_type      scl_in;
   logic [VB-1:0] res_ff;
   logic [VB-1:0] res_in;
   logic          sat_ff;
   logic          sat_in;

   always_comb begin
      logic [VB:0] d;
      d           = {end_v[VB-1], end_v} - {start_v[VB-1], start_v};
      line_in.s   = start_v;
      line_in.neg = d[VB];
      line_in.mag = d[VB] ? -d : d;
   end

   // mag becomes |d| * w, rounded half up
   always_comb begin
      logic [VB+F+1:0] prod;
      logic [VB+F+1:0] sc;
      prod       = (VB+F+2)'(line_ff[DLY-1].mag) * (VB+F+2)'(weight);
      sc         = (prod + ((VB+F+2)'(1) << (F - 1))) >> F;
      scl_in     = line_ff[DLY-1];
      scl_in.mag = sc[VB:0];
   end

   always_comb begin
      logic signed [VB+1:0] se;
      logic signed [VB+1:0] pe;
      logic signed [VB+1:0] sum;
      se  = {{2{scl_ff.s[VB-1]}}, scl_ff.s};
      pe  = {1'b0, scl_ff.mag};
      sum = scl_ff.neg ? se - pe : se + pe;
      sat_in = !(sum[VB+1:VB-1] == 3'b000 || sum[VB+1:VB-1] == 3'b111);
      if (sat_in) res_in = sum[VB+1] ? VMIN : VMAX;
      else        res_in = sum[VB-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= line_in;
         for (int k = 1; k < DLY; k++) line_ff[k] <= line_ff[k-1];
         scl_ff <= scl_in;
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign result = res_ff;
   assign sat    = sat_ff;

endmodule

[rtl/ecurve_merge.sv]
module ecurve_merge #(
   parameter int VALUE_BITS = ecurve_pkg::VALUE_BITS
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           pipe_valid,
   input  logic [ecurve_pkg::LANES-1:0][VALUE_BITS-1:0]   lane_val,
   input  logic [ecurve_pkg::LANES-1:0]                   lane_sat,
   input  logic                                           out_ready,
   output logic                                           out_valid,
   output logic [ecurve_pkg::LANES-1:0][VALUE_BITS-1:0]   out_val,
   output logic                                           out_sat,
   output logic                                           hold
);
   typedef struct packed {
      logic [ecurve_pkg::LANES-1:0][VALUE_BITS-1:0] val;
      logic                                         sat;
   } item_type;

   item_type out_ff, out_in, skid_ff, skid_in, fresh;
   logic     out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;
   logic     take;

   assign fresh.val = lane_val;
   assign fresh.sat = |lane_sat;
   assign take      = out_vld_ff & out_ready;

   always_comb begin
      out_in      = out_ff;
      skid_in     = skid_ff;
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         // pipeline is held; drain the skid item first
         if (take) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (!out_vld_ff || take) begin
         out_in     = fresh;
         out_vld_in = pipe_valid;
      end else if (pipe_valid) begin
         skid_in     = fresh;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid = out_vld_ff;
   assign out_val   = out_ff.val;
   assign out_sat   = out_ff.sat;
   assign hold      = skid_vld_ff;

endmodule

[rtl/easing_curve_interpolator_top.sv]
// channel | dir | handshake        | payload
// req     | in  | valid / ready    | opcode, start_x, start_y, end_x, end_y, progress
// rsp     | out | valid / ready    | value_x, value_y, saturated
//
// One item per cycle while rsp is not stalled.
// Latency is set by the square-root unit, one digit per stage, FRAC_BITS + 1 stages.
// Reset clears only the valid bits of the pipeline, the output and the skid slot.
// When rsp stalls, one more item lands in the skid slot, then req.ready drops.
module easing_curve_interpolator_top #(
   parameter int FRAC_BITS  = ecurve_pkg::FRAC_BITS,
   parameter int VALUE_BITS = ecurve_pkg::VALUE_BITS
) (
   input logic           clock,
   input logic           reset,
   ecurve_req_if.sink    req,
   ecurve_rsp_if.source  rsp
);
   localparam int LAST = FRAC_BITS + 6;

   logic [LAST:0]                                 vld_ff, vld_in;
   logic                                          en, hold;
   logic [FRAC_BITS:0]                            weight;
   logic signed [VALUE_BITS-1:0]                  lane_start [ecurve_pkg::LANES];
   logic signed [VALUE_BITS-1:0]                  lane_end   [ecurve_pkg::LANES];
   logic [ecurve_pkg::LANES-1:0][VALUE_BITS-1:0]  lane_val;
   logic [ecurve_pkg::LANES-1:0]                  lane_sat;
   logic [ecurve_pkg::LANES-1:0][VALUE_BITS-1:0]  out_val;

   assign en        = ~hold;
   assign req.ready = en;
   assign vld_in    = {vld_ff[LAST-1:0], req.valid & en};

   always_ff @(posedge clock) begin
      if (reset)   vld_ff <= '0;
      else if (en) vld_ff <= vld_in;
   end

   assign lane_start[0] = req.start_x;
   assign lane_start[1] = req.start_y;
   assign lane_end[0]   = req.end_x;
   assign lane_end[1]   = req.end_y;

   ecurve_weight #(.FRAC_BITS(FRAC_BITS)) u_weight (
      .clock    (clock),
      .en       (en),
      .opcode   (req.opcode),
      .progress (req.progress),
      .weight   (weight)
   );

   for (genvar l = 0; l < ecurve_pkg::LANES; l++) begin : g_lane
      ecurve_lane #(.FRAC_BITS(FRAC_BITS), .VALUE_BITS(VALUE_BITS)) u_lane (
         .clock   (clock),
         .en      (en),
         .start_v (lane_start[l]),
         .end_v   (lane_end[l]),
         .weight  (weight),
         .result  (lane_val[l]),
         .sat     (lane_sat[l])
      );
   end

   ecurve_merge #(.VALUE_BITS(VALUE_BITS)) u_merge (
      .clock      (clock),
      .reset      (reset),
      .pipe_valid (vld_ff[LAST]),
      .lane_val   (lane_val),
      .lane_sat   (lane_sat),
      .out_ready  (rsp.ready),
      .out_valid  (rsp.valid),
      .out_val    (out_val),
      .out_sat    (rsp.saturated),
      .hold       (hold)
   );

   assign rsp.value_x = out_val[0];
   assign rsp.value_y = out_val[1];

endmodule

[rtl/ecurve_checker.sv]
module ecurve_checker #(
   parameter int VALUE_BITS = ecurve_pkg::VALUE_BITS
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [VALUE_BITS-1:0] rsp_value_x,
   input logic [VALUE_BITS-1:0] rsp_value_y,
   input logic                  rsp_saturated
);
   // hold a stalled item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_x)
         && $stable(rsp_value_y) && $stable(rsp_saturated))
      else $error("stalled rsp item changed");

   // weight never exceeds one, so results stay between start and end
   a_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_saturated)
      else $error("saturation on in-range item");

   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("req ready dropped without rsp stall");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("not empty after reset");

   a_req_seen: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> $past(rsp_valid))
      else $error("req stalled with empty output");

endmodule

bind easing_curve_interpolator_top ecurve_checker #(.VALUE_BITS(VALUE_BITS)) u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_value_x   (rsp.value_x),
   .rsp_value_y   (rsp.value_y),
   .rsp_saturated (rsp.saturated)
);
